### src/tdp_pkg.sv
package tdp_pkg;

    // Item kinds carried on the input tuser
    typedef enum logic [1:0] {
        ACT_HEADER  = 2'd0,
        ACT_ENTRY   = 2'd1,
        ACT_ELEMENT = 2'd2,
        ACT_FINISH  = 2'd3
    } action_t;

    // Status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_VERSION  = 3'd1;
    localparam logic [2:0] ST_MIXED    = 3'd2;
    localparam logic [2:0] ST_BAD_DEPTH = 3'd3;
    localparam logic [2:0] ST_COMPRESS = 3'd4;
    localparam logic [2:0] ST_PLANAR   = 3'd5;
    localparam logic [2:0] ST_COLOR    = 3'd6;

    // Pixel format codes
    localparam logic [1:0] FMT_MONO8  = 2'd0;
    localparam logic [1:0] FMT_MONO16 = 2'd1;
    localparam logic [1:0] FMT_RGB8   = 2'd2;
    localparam logic [1:0] FMT_RGB16  = 2'd3;

    // Header and tag constants
    localparam logic [15:0] TIFF_MAGIC   = 16'd42;
    localparam logic [15:0] BE_MARK      = {8'h4D, 8'h4D};  // "MM"
    localparam logic [15:0] TAG_WIDTH    = 16'h0100;
    localparam logic [15:0] TAG_HEIGHT   = 16'h0101;
    localparam logic [15:0] TAG_DEPTH    = 16'h0102;
    localparam logic [15:0] TAG_COMPRESS = 16'h0103;
    localparam logic [15:0] TAG_PHOTO    = 16'h0106;
    localparam logic [15:0] TAG_CHANNELS = 16'h0115;
    localparam logic [15:0] TAG_PLANAR   = 16'h011C;
    localparam logic [15:0] TYPE_SHORT   = 16'd3;
    localparam logic [15:0] TYPE_LONG    = 16'd4;

    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 112;

    // One input beat
    typedef struct packed {
        action_t     action;
        logic [15:0] word_a;
        logic [15:0] word_b;
        logic [31:0] entry_count;
        logic [31:0] entry_value;
        logic        element_last;
    } item_t;

    // Parser state kept between beats
    typedef struct packed {
        logic        big_endian;
        logic [2:0]  error_code;
        logic [31:0] width;
        logic [31:0] height;
        logic [15:0] sample_bits;
        logic [31:0] channels;
        logic [31:0] photometric;
        logic        photo_seen;
        logic [15:0] depth_first;
        logic        depth_pending;
        logic        first_arrived;
    } parse_state_t;

    // One result beat
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] decoded_value;
        logic        file_big_endian;
        logic [31:0] image_width;
        logic [31:0] image_height;
        logic [1:0]  pixel_format;
        logic        invert_gray;
        logic        swap_words;
        logic        format_valid;
    } result_t;

    function automatic logic [15:0] sw16(input logic be, input logic [15:0] v);
        return be ? {v[7:0], v[15:8]} : v;
    endfunction

    function automatic logic [31:0] sw32(input logic be, input logic [31:0] v);
        return be ? {v[7:0], v[15:8], v[23:16], v[31:24]} : v;
    endfunction

    function automatic logic depth_ok(input logic [31:0] d);
        return (d == 32'd8) || (d == 32'd16);
    endfunction

endpackage

### src/tdp_core.sv
module tdp_core
    import tdp_pkg::*;
(
    input  item_t        item,
    input  parse_state_t cur,
    output parse_state_t nxt,
    output result_t      res
);

    logic [15:0] tag;
    logic [15:0] etype;
    logic [31:0] cnt;
    logic [31:0] decoded;
    logic [15:0] el;
    logic [15:0] d_arr;
    logic        gray;
    logic        rgb;

    // Endianness fix of the entry fields under the current byte order
    assign tag   = sw16(cur.big_endian, item.word_a);
    assign etype = sw16(cur.big_endian, item.word_b);
    assign cnt   = sw32(cur.big_endian, item.entry_count);
    assign el    = item.entry_value[15:0];

    always_comb
    begin
        nxt      = cur;
        decoded  = '0;
        d_arr    = '0;
        gray     = 1'b0;
        rgb      = 1'b0;
        res.pixel_format = FMT_MONO8;
        res.invert_gray  = 1'b0;
        res.swap_words   = 1'b0;
        res.format_valid = 1'b0;

        case (item.action)
            ACT_HEADER:
            begin
                nxt = '0;
                nxt.big_endian = (item.word_a == BE_MARK);
                decoded = {16'd0, sw16(nxt.big_endian, item.word_b)};
                if (decoded != {16'd0, TIFF_MAGIC})
                begin
                    nxt.error_code = ST_VERSION;
                end
            end
            ACT_ENTRY:
            begin
                // value word: long or array -> full swap, single short -> low half
                if ((cnt > 32'd1) || (etype == TYPE_LONG))
                begin
                    decoded = sw32(cur.big_endian, item.entry_value);
                end
                else if ((cnt == 32'd1) && (etype == TYPE_SHORT))
                begin
                    decoded = {16'd0, sw16(cur.big_endian, item.entry_value[15:0])};
                end
                else
                begin
                    decoded = item.entry_value;
                end
                if (cur.error_code == ST_OK)
                begin
                    nxt.depth_pending = 1'b0;
                    nxt.first_arrived = 1'b0;
                    nxt.depth_first   = '0;
                    case (tag)
                        TAG_WIDTH:  nxt.width  = decoded;
                        TAG_HEIGHT: nxt.height = decoded;
                        TAG_DEPTH:
                        begin
                            if (cnt == 32'd1)
                            begin
                                if (depth_ok(decoded))
                                begin
                                    nxt.sample_bits = decoded[15:0];
                                end
                                else
                                begin
                                    nxt.error_code = ST_BAD_DEPTH;
                                end
                            end
                            else if (cnt == 32'd0)
                            begin
                                nxt.error_code = ST_BAD_DEPTH;
                            end
                            else
                            begin
                                nxt.depth_pending = 1'b1;
                            end
                        end
                        TAG_COMPRESS:
                        begin
                            if (decoded != 32'd1)
                            begin
                                nxt.error_code = ST_COMPRESS;
                            end
                        end
                        TAG_PHOTO:
                        begin
                            nxt.photometric = decoded;
                            nxt.photo_seen  = 1'b1;
                        end
                        TAG_CHANNELS: nxt.channels = decoded;
                        TAG_PLANAR:
                        begin
                            if (decoded != 32'd1)
                            begin
                                nxt.error_code = ST_PLANAR;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ACT_ELEMENT:
            begin
                decoded = {16'd0, sw16(cur.big_endian, el)};
                if ((cur.error_code == ST_OK) && cur.depth_pending)
                begin
                    // all raw elements must match the first one
                    if (!cur.first_arrived)
                    begin
                        nxt.depth_first   = el;
                        nxt.first_arrived = 1'b1;
                    end
                    else if (el != cur.depth_first)
                    begin
                        nxt.error_code = ST_MIXED;
                    end
                    d_arr = sw16(cur.big_endian, nxt.depth_first);
                    if ((nxt.error_code == ST_OK) && item.element_last)
                    begin
                        if (depth_ok({16'd0, d_arr}))
                        begin
                            nxt.sample_bits = d_arr;
                        end
                        else
                        begin
                            nxt.error_code = ST_BAD_DEPTH;
                        end
                    end
                    if ((nxt.error_code != ST_OK) || item.element_last)
                    begin
                        nxt.depth_pending = 1'b0;
                        nxt.first_arrived = 1'b0;
                    end
                end
            end
            default:
            begin
                // finish: color model first, then depth
                gray = (cur.channels == 32'd1) && cur.photo_seen &&
                       ((cur.photometric == 32'd0) || (cur.photometric == 32'd1));
                rgb  = (cur.channels == 32'd3) && cur.photo_seen &&
                       (cur.photometric == 32'd2);
                if (cur.error_code == ST_OK)
                begin
                    if (!gray && !rgb)
                    begin
                        nxt.error_code = ST_COLOR;
                    end
                    else if (cur.depth_pending || !depth_ok({16'd0, cur.sample_bits}))
                    begin
                        nxt.error_code = ST_BAD_DEPTH;
                    end
                    if (nxt.error_code == ST_OK)
                    begin
                        res.pixel_format = {rgb, cur.sample_bits == 16'd16};
                        res.invert_gray  = gray && (cur.photometric == 32'd0);
                        res.swap_words   = (cur.sample_bits == 16'd16) && cur.big_endian;
                        res.format_valid = 1'b1;
                    end
                end
            end
        endcase

        res.status          = nxt.error_code;
        res.decoded_value   = decoded;
        res.file_big_endian = nxt.big_endian;
        res.image_width     = nxt.width;
        res.image_height    = nxt.height;
    end

endmodule

### src/tiff_directory_parser_unit.sv
// TIFF directory parser. Feed a header beat, then the directory entries as
// raw file-order words, any bits-per-sample array elements, and a finish
// beat; every input beat yields exactly one result beat. The block takes one
// beat per clock unless the result side stalls: the beat is captured in an
// input register, decoded and applied to the parser state by one level of
// swap/compare logic, and lands in the result register. A stall on the
// result side holds the pipe; the input side keeps flowing as long as the
// result register is free or being drained in the same cycle.
module tiff_directory_parser_unit
    import tdp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // word_a[15:0], word_b[31:16], entry_count[63:32], entry_value[95:64]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tlast,   // element_last
    // action[1:0]
    input  logic [1:0]            s_axis_tuser,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // status[2:0], decoded_value[34:3], file_big_endian[35],
    // image_width[67:36], image_height[99:68], pixel_format[101:100],
    // invert_gray[102], swap_words[103], format_valid[104], zero[111:105]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic         in_valid_reg;
    item_t        in_item_reg;
    logic         out_valid_reg;
    result_t      out_res_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    result_t      res_next;
    logic         advance;

    // Pipe moves when the result register can take the decoded beat
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.action       <= action_t'(s_axis_tuser);
            in_item_reg.word_a       <= s_axis_tdata[15:0];
            in_item_reg.word_b       <= s_axis_tdata[31:16];
            in_item_reg.entry_count  <= s_axis_tdata[63:32];
            in_item_reg.entry_value  <= s_axis_tdata[95:64];
            in_item_reg.element_last <= s_axis_tlast;
        end
    end

    tdp_core u_core
    (
        .item (in_item_reg),
        .cur  (state_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    // Parser state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0,
                            out_res_reg.format_valid,
                            out_res_reg.swap_words,
                            out_res_reg.invert_gray,
                            out_res_reg.pixel_format,
                            out_res_reg.image_height,
                            out_res_reg.image_width,
                            out_res_reg.file_big_endian,
                            out_res_reg.decoded_value,
                            out_res_reg.status};

    // A reported format always comes with a clean status
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.format_valid) |-> (out_res_reg.status == ST_OK))
        else $error("format_valid with nonzero status");

    // Gray inversion only applies to mono formats
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.invert_gray) |-> !out_res_reg.pixel_format[1])
        else $error("invert_gray on an RGB format");

    // Errors stay until the next header
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (state_reg.error_code != ST_OK) && (in_item_reg.action != ACT_HEADER))
        |=> (state_reg.error_code == $past(state_reg.error_code)))
        else $error("sticky error changed without a header");

    // Parser state only moves when a beat goes to the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("parser state changed without a beat");

    // Input side is only held off while a beat waits in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg))
        else $error("input stalled with a free pipe");

endmodule

### sim/tiff_directory_parser_unit_test.sv
module tiff_directory_parser_unit_test;
    import tdp_pkg::*;

    // Byte order marks and photometric codes used by the stimulus
    localparam logic [15:0] LE_MARK          = {8'h49, 8'h49};  // "II"
    localparam logic [31:0] PHOTO_WHITE_ZERO = 32'd0;
    localparam logic [31:0] PHOTO_BLACK_ZERO = 32'd1;
    localparam logic [31:0] PHOTO_RGB        = 32'd2;
    localparam logic [15:0] DEPTH_8          = 16'd8;
    localparam logic [15:0] DEPTH_16         = 16'd16;
    localparam int          STALL_LIMIT      = 2000;
    localparam int          HOLD_CYCLES      = 200;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tlast;
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // Parser state as the scoreboard tracks it
    logic        p_big_endian;
    logic [2:0]  p_error;
    logic [31:0] p_width;
    logic [31:0] p_height;
    logic [15:0] p_depth;
    logic [31:0] p_channels;
    logic [31:0] p_photo;
    logic        p_photo_seen;
    logic [15:0] p_depth_first;
    logic        p_depth_open;
    logic        p_first_seen;

    result_t predicted_beats[$];

    int  mismatches     = 0;
    int  beats_sent     = 0;
    int  beats_checked  = 0;
    int  streams_sent   = 0;
    int  formats_valid  = 0;
    int  error_beats    = 0;
    int  idle_cycles    = 0;
    int  rx_hold_len    = 0;
    bit  tx_idle_on     = 1'b1;
    bit  rx_idle_on     = 1'b1;

    tiff_directory_parser_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Scoreboard model
    // ---------------------------------------------------------------

    function automatic logic [15:0] order16(input logic be, input logic [15:0] v);
        order16 = be ? {v[7:0], v[15:8]} : v;
    endfunction

    function automatic logic [31:0] order32(input logic be, input logic [31:0] v);
        order32 = be ? {order16(1'b1, v[15:0]), order16(1'b1, v[31:16])} : v;
    endfunction

    function automatic logic is_sample_depth(input logic [31:0] d);
        is_sample_depth = (d == 32'(DEPTH_8)) || (d == 32'(DEPTH_16));
    endfunction

    function automatic void clear_parse_state();
        p_big_endian  = 1'b0;
        p_error       = ST_OK;
        p_width       = '0;
        p_height      = '0;
        p_depth       = '0;
        p_channels    = '0;
        p_photo       = '0;
        p_photo_seen  = 1'b0;
        p_depth_first = '0;
        p_depth_open  = 1'b0;
        p_first_seen  = 1'b0;
    endfunction

    // Apply one beat to the tracked state and return the result it must give
    function automatic result_t parse_item(input item_t it);
        result_t     r;
        logic [15:0] tag;
        logic [15:0] kind;
        logic [31:0] cnt;
        logic [15:0] el;
        logic        gray;
        logic        rgb;
        r = '0;
        case (it.action)
            ACT_HEADER:
            begin
                clear_parse_state();
                p_big_endian = (it.word_a == BE_MARK);
                r.decoded_value = {16'h0, order16(p_big_endian, it.word_b)};
                if (r.decoded_value != 32'(TIFF_MAGIC))
                    p_error = ST_VERSION;
            end
            ACT_ENTRY:
            begin
                tag  = order16(p_big_endian, it.word_a);
                kind = order16(p_big_endian, it.word_b);
                cnt  = order32(p_big_endian, it.entry_count);
                if (cnt > 32'd1 || kind == TYPE_LONG)
                    r.decoded_value = order32(p_big_endian, it.entry_value);
                else if (cnt == 32'd1 && kind == TYPE_SHORT)
                    r.decoded_value = {16'h0, order16(p_big_endian, it.entry_value[15:0])};
                else
                    r.decoded_value = it.entry_value;
                if (p_error == ST_OK)
                begin
                    // any entry drops an open depth array
                    p_depth_open  = 1'b0;
                    p_first_seen  = 1'b0;
                    p_depth_first = '0;
                    case (tag)
                        TAG_WIDTH:    p_width = r.decoded_value;
                        TAG_HEIGHT:   p_height = r.decoded_value;
                        TAG_DEPTH:
                        begin
                            if (cnt == 32'd1)
                            begin
                                if (is_sample_depth(r.decoded_value))
                                    p_depth = r.decoded_value[15:0];
                                else
                                    p_error = ST_BAD_DEPTH;
                            end
                            else if (cnt == 32'd0)
                                p_error = ST_BAD_DEPTH;
                            else
                                p_depth_open = 1'b1;
                        end
                        TAG_COMPRESS: if (r.decoded_value != 32'd1) p_error = ST_COMPRESS;
                        TAG_PHOTO:
                        begin
                            p_photo      = r.decoded_value;
                            p_photo_seen = 1'b1;
                        end
                        TAG_CHANNELS: p_channels = r.decoded_value;
                        TAG_PLANAR:   if (r.decoded_value != 32'd1) p_error = ST_PLANAR;
                        default:      ;
                    endcase
                end
            end
            ACT_ELEMENT:
            begin
                el = it.entry_value[15:0];
                r.decoded_value = {16'h0, order16(p_big_endian, el)};
                if (p_error == ST_OK && p_depth_open)
                begin
                    // raw elements are compared against the first one
                    if (!p_first_seen)
                    begin
                        p_depth_first = el;
                        p_first_seen  = 1'b1;
                    end
                    else if (el != p_depth_first)
                        p_error = ST_MIXED;
                    if (p_error == ST_OK && it.element_last)
                    begin
                        if (is_sample_depth({16'h0, order16(p_big_endian, p_depth_first)}))
                            p_depth = order16(p_big_endian, p_depth_first);
                        else
                            p_error = ST_BAD_DEPTH;
                    end
                    if (p_error != ST_OK || it.element_last)
                    begin
                        p_depth_open = 1'b0;
                        p_first_seen = 1'b0;
                    end
                end
            end
            default:
            begin
                if (p_error == ST_OK)
                begin
                    gray = p_channels == 32'd1 && p_photo_seen &&
                           (p_photo == PHOTO_WHITE_ZERO || p_photo == PHOTO_BLACK_ZERO);
                    rgb  = p_channels == 32'd3 && p_photo_seen && p_photo == PHOTO_RGB;
                    // color model first, then depth
                    if (!gray && !rgb)
                        p_error = ST_COLOR;
                    else if (p_depth_open || !is_sample_depth({16'h0, p_depth}))
                        p_error = ST_BAD_DEPTH;
                    if (p_error == ST_OK)
                    begin
                        if (rgb)
                            r.pixel_format = (p_depth == DEPTH_16) ? FMT_RGB16 : FMT_RGB8;
                        else
                            r.pixel_format = (p_depth == DEPTH_16) ? FMT_MONO16 : FMT_MONO8;
                        r.invert_gray  = gray && p_photo == PHOTO_WHITE_ZERO;
                        r.swap_words   = p_depth == DEPTH_16 && p_big_endian;
                        r.format_valid = 1'b1;
                    end
                end
            end
        endcase
        r.status          = p_error;
        r.file_big_endian = p_big_endian;
        r.image_width     = p_width;
        r.image_height    = p_height;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------

    task automatic send_item(input item_t it);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.entry_value, it.entry_count, it.word_b, it.word_a};
        s_axis_tlast  <= it.element_last;
        s_axis_tuser  <= it.action;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted_beats.push_back(parse_item(it));
        beats_sent++;
    endtask

    task automatic send_header(input logic [15:0] id, input logic [15:0] version);
        item_t it;
        it.action       = ACT_HEADER;
        it.word_a       = id;
        it.word_b       = order16(id == BE_MARK, version);
        it.entry_count  = $urandom;
        it.entry_value  = $urandom;
        it.element_last = 1'($urandom_range(0, 1));
        send_item(it);
    endtask

    task automatic send_entry(input logic be, input logic [15:0] tag,
                              input logic [15:0] kind, input logic [31:0] cnt,
                              input logic [31:0] value);
        item_t it;
        it.action       = ACT_ENTRY;
        it.word_a       = order16(be, tag);
        it.word_b       = order16(be, kind);
        it.entry_count  = order32(be, cnt);
        // a single short sits in the first two file bytes, padding is junk
        if (cnt == 32'd1 && kind == TYPE_SHORT)
            it.entry_value = {16'($urandom), order16(be, value[15:0])};
        else
            it.entry_value = order32(be, value);
        it.element_last = 1'($urandom_range(0, 1));
        send_item(it);
    endtask

    task automatic send_element(input logic be, input logic [15:0] depth, input logic last);
        item_t it;
        it.action       = ACT_ELEMENT;
        it.word_a       = 16'($urandom);
        it.word_b       = 16'($urandom);
        it.entry_count  = $urandom;
        it.entry_value  = {16'($urandom), order16(be, depth)};
        it.element_last = last;
        send_item(it);
    endtask

    task automatic send_finish();
        item_t it;
        it.action       = ACT_FINISH;
        it.word_a       = 16'($urandom);
        it.word_b       = 16'($urandom);
        it.entry_count  = $urandom;
        it.entry_value  = $urandom;
        it.element_last = 1'($urandom_range(0, 1));
        send_item(it);
    endtask

    // Single-valued entry as a short, a long, or an odd type kept raw
    task automatic send_sized(input logic be, input logic [15:0] tag, input logic [31:0] value);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            send_entry(be, tag, 16'($urandom_range(0, 12)), 32'd1, value);
        else if (pick < 6 && value <= 32'h0000_FFFF)
            send_entry(be, tag, TYPE_SHORT, 32'd1, value);
        else
            send_entry(be, tag, TYPE_LONG, 32'd1, value);
    endtask

    function automatic logic [31:0] pick_dimension();
        pick_dimension = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(1, 4096);
    endfunction

    // Depth as one value or as an array of elements, now and then broken
    task automatic send_depth(input logic be, input logic [15:0] bits, input int chans);
        int n;
        int k;
        int odd_at;
        int cut;
        if ($urandom_range(0, 2) == 0)
        begin
            if ($urandom_range(0, 19) == 0)
                send_entry(be, TAG_DEPTH, TYPE_SHORT, 32'd0, {16'h0, bits});
            else
                send_sized(be, TAG_DEPTH, {16'h0, bits});
        end
        else
        begin
            n = (chans > 1 && chans < 6) ? chans : $urandom_range(2, 4);
            send_entry(be, TAG_DEPTH, TYPE_SHORT, n, $urandom_range(8, 512));
            odd_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, n - 1) : n;
            cut    = ($urandom_range(0, 11) == 0) ? $urandom_range(1, n - 1) : n;
            for (k = 0; k < cut; k++)
                send_element(be, (k == odd_at) ? (bits ^ 16'd24) : bits, k == n - 1);
        end
    endtask

    // One directory stream: header, mostly sane entries, optional finish
    task automatic send_random_file();
        logic        be;
        int          chans;
        logic [31:0] photo;
        logic [15:0] bits;
        int          step;
        be    = 1'($urandom_range(0, 1));
        chans = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5)
                                            : (($urandom_range(0, 1) == 1) ? 3 : 1);
        if ($urandom_range(0, 9) == 0)
            photo = $urandom_range(0, 4);
        else
            photo = (chans == 3) ? PHOTO_RGB : $urandom_range(0, 1);
        if ($urandom_range(0, 9) == 0)
            bits = 16'($urandom_range(0, 32));
        else
            bits = ($urandom_range(0, 1) == 1) ? DEPTH_16 : DEPTH_8;

        send_header(be ? BE_MARK : (($urandom_range(0, 15) == 0) ? 16'($urandom) : LE_MARK),
                    ($urandom_range(0, 15) == 0) ? 16'($urandom) : TIFF_MAGIC);
        for (step = 0; step < 7; step++)
        begin
            if ($urandom_range(0, 4) == 0)
                send_entry(be, 16'($urandom), 16'($urandom_range(1, 12)),
                           $urandom_range(0, 4), $urandom);
            if ($urandom_range(0, 11) != 0)
            begin
                case (step)
                    0: send_sized(be, TAG_WIDTH, pick_dimension());
                    1: send_sized(be, TAG_HEIGHT, pick_dimension());
                    2: send_sized(be, TAG_CHANNELS, chans);
                    3: send_sized(be, TAG_PHOTO, photo);
                    4: send_depth(be, bits, chans);
                    5: send_sized(be, TAG_COMPRESS,
                                  ($urandom_range(0, 9) == 0) ? $urandom_range(2, 8) : 1);
                    default: send_sized(be, TAG_PLANAR,
                                  ($urandom_range(0, 9) == 0) ? $urandom_range(2, 3) : 1);
                endcase
            end
        end
        if ($urandom_range(0, 9) == 0)
            send_element(be, 16'($urandom), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 11) != 0)
            send_finish();
        streams_sent++;
    endtask

    // Park the input and wait until every predicted beat has come back
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (predicted_beats.size() != 0);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    task automatic test_directed();
        // beats before any header: little-endian, color model refused
        send_entry(1'b0, TAG_WIDTH, TYPE_LONG, 32'd1, 32'hFFFF_FFFF);
        send_finish();
        // big-endian RGB16 with a uniform depth array and a stray element
        send_header(BE_MARK, TIFF_MAGIC);
        send_entry(1'b1, TAG_WIDTH, TYPE_SHORT, 32'd1, 32'h0000_1234);
        send_entry(1'b1, TAG_HEIGHT, TYPE_LONG, 32'd1, 32'h00AB_CDEF);
        send_entry(1'b1, TAG_CHANNELS, TYPE_SHORT, 32'd1, 32'd3);
        send_entry(1'b1, TAG_PHOTO, TYPE_SHORT, 32'd1, PHOTO_RGB);
        send_entry(1'b1, TAG_COMPRESS, TYPE_SHORT, 32'd1, 32'd1);
        send_entry(1'b1, TAG_PLANAR, TYPE_SHORT, 32'd1, 32'd1);
        send_entry(1'b1, TAG_DEPTH, TYPE_SHORT, 32'd3, 32'd200);
        send_element(1'b1, DEPTH_16, 1'b0);
        send_element(1'b1, DEPTH_16, 1'b0);
        send_element(1'b1, DEPTH_16, 1'b1);
        send_element(1'b1, DEPTH_8, 1'b1);
        send_finish();
        // little-endian white-is-zero gray; an entry drops the open array
        send_header(LE_MARK, TIFF_MAGIC);
        send_entry(1'b0, TAG_CHANNELS, TYPE_SHORT, 32'd1, 32'd1);
        send_entry(1'b0, TAG_PHOTO, TYPE_LONG, 32'd1, PHOTO_WHITE_ZERO);
        send_entry(1'b0, TAG_DEPTH, 16'hFFFF, 32'hFFFF_FFFF, 32'd64);
        send_element(1'b0, DEPTH_8, 1'b0);
        send_entry(1'b0, TAG_DEPTH, TYPE_SHORT, 32'd1, DEPTH_8);
        send_finish();
        // bad version is sticky up to the finish
        send_header(16'hFFFF, 16'hFFFF);
        send_finish();
        // mixed depth elements, then compression refused
        send_header(BE_MARK, TIFF_MAGIC);
        send_entry(1'b1, TAG_DEPTH, TYPE_SHORT, 32'd2, 32'd300);
        send_element(1'b1, DEPTH_8, 1'b0);
        send_element(1'b1, DEPTH_16, 1'b1);
        send_header(LE_MARK, TIFF_MAGIC);
        send_entry(1'b0, TAG_COMPRESS, TYPE_SHORT, 32'd1, 32'd5);
        wait_for_results();
    endtask

    task automatic test_random_files();
        while (beats_sent < 1200)
            send_random_file();
        wait_for_results();
    endtask

    task automatic test_back_to_back();
        int k;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        for (k = 0; k < 12; k++)
            send_random_file();
        wait_for_results();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Receiver holds off while the sender keeps offering beats
    task automatic test_output_hold();
        int k;
        tx_idle_on  = 1'b0;
        rx_hold_len = HOLD_CYCLES;
        for (k = 0; k < 4; k++)
            send_random_file();
        wait_for_results();
        tx_idle_on = 1'b1;
    endtask

    // Loosely formed beats with all fields random
    task automatic test_noise();
        item_t it;
        int    k;
        for (k = 0; k < 250; k++)
        begin
            it.action = action_t'(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3));
            if (it.action == ACT_HEADER)
            begin
                case ($urandom_range(0, 2))
                    0:       it.word_a = BE_MARK;
                    1:       it.word_a = LE_MARK;
                    default: it.word_a = 16'($urandom);
                endcase
                case ($urandom_range(0, 2))
                    0:       it.word_b = TIFF_MAGIC;
                    1:       it.word_b = order16(1'b1, TIFF_MAGIC);
                    default: it.word_b = 16'($urandom);
                endcase
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       it.word_a = {8'h01, 8'($urandom_range(0, 31))};
                    1:       it.word_a = {8'($urandom_range(0, 31)), 8'h01};
                    default: it.word_a = 16'($urandom);
                endcase
                it.word_b = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 5)) : 16'($urandom);
            end
            it.entry_count  = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 3) : $urandom;
            it.entry_value  = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 20) : $urandom;
            it.element_last = 1'($urandom_range(0, 1));
            send_item(it);
        end
        wait_for_results();
    endtask

    // ---------------------------------------------------------------
    // Output side
    // ---------------------------------------------------------------

    initial
    begin
        int pause;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold_len > 0)
            begin
                pause       = rx_hold_len;
                rx_hold_len = 0;
            end
            else
                pause = rx_idle_on ? $urandom_range(0, 8) : 0;
            if (pause > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            beats_checked++;
            if (m_axis_tdata[104])
                formats_valid++;
            if (m_axis_tdata[2:0] != ST_OK)
                error_beats++;
            if (predicted_beats.size() == 0)
            begin
                $error("result beat with nothing predicted, tdata %0h", m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = predicted_beats.pop_front();
                check_field("status", 32'(want.status), 32'(m_axis_tdata[2:0]));
                check_field("decoded_value", want.decoded_value, m_axis_tdata[34:3]);
                check_field("file_big_endian", 32'(want.file_big_endian),
                            32'(m_axis_tdata[35]));
                check_field("image_width", want.image_width, m_axis_tdata[67:36]);
                check_field("image_height", want.image_height, m_axis_tdata[99:68]);
                check_field("pixel_format", 32'(want.pixel_format),
                            32'(m_axis_tdata[101:100]));
                check_field("invert_gray", 32'(want.invert_gray), 32'(m_axis_tdata[102]));
                check_field("swap_words", 32'(want.swap_words), 32'(m_axis_tdata[103]));
                check_field("format_valid", 32'(want.format_valid), 32'(m_axis_tdata[104]));
            end
        end
    end

    // Watchdog on cycles with no beat moving on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------

    initial
    begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        s_axis_tuser  <= ACT_HEADER;
        rst_n         <= 1'b0;
        clear_parse_state();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_files();
        test_back_to_back();
        test_output_hold();
        test_noise();

        repeat (8) @(posedge clk);
        $display("Run covered %0d input beats in %0d random directory streams plus directed",
                 beats_sent, streams_sent);
        $display("and noise beats; %0d results checked, %0d valid formats, %0d error statuses.",
                 beats_checked, formats_valid, error_beats);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
